@@ sv/cts_pkg.sv @@
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, codes and character helpers for the calculator token scanner.
// ----------------------------------------------------------------------------
package cts_pkg;

    // default accumulator width
    localparam int ACC_WIDTH_DEF = 31;
    // width of the reported integer value
    localparam int VALUE_W       = 31;
    // entries in the result queue
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    // length of the keyword
    localparam logic [2:0] KW_LEN = 3'd5;

    // token kinds
    typedef enum logic [3:0] {
        KIND_EOF   = 4'd0,
        KIND_ERROR = 4'd1,
        KIND_PRINT = 4'd2,
        KIND_INT   = 4'd3,
        KIND_OPEN  = 4'd4,
        KIND_CLOSE = 4'd5,
        KIND_PLUS  = 4'd6,
        KIND_MINUS = 4'd7,
        KIND_MULT  = 4'd8,
        KIND_DIV   = 4'd9
    } kind_t;

    // error causes
    typedef enum logic [1:0] {
        CAUSE_NONE = 2'd0,
        CAUSE_WORD = 2'd1,
        CAUSE_CHAR = 2'd2
    } cause_t;

    // scanner state, one-hot
    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_NUM  = 3'b010,
        MODE_WORD = 3'b100
    } mode_t;

    // input op codes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOF  = 1'b1;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // one result item
    typedef struct packed {
        kind_t              kind;
        logic [VALUE_W-1:0] value;
        cause_t             cause;
        logic               last;
    } token_t;

    // results produced by one input item
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } scan_out_t;

    function automatic token_t make_tok(kind_t kind, logic [VALUE_W-1:0] value,
                                        cause_t cause);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.cause = cause;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    // keyword characters of "print"
    function automatic logic [7:0] kw_char(logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h70;
            3'd1:    c = 8'h72;
            3'd2:    c = 8'h69;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h74;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // symbol token for a byte seen while idle, error when not a symbol
    function automatic kind_t sym_kind(logic [7:0] c);
        kind_t k;
        unique case (c)
            CH_OPEN:  k = KIND_OPEN;
            CH_CLOSE: k = KIND_CLOSE;
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_MULT;
            CH_SLASH: k = KIND_DIV;
            default:  k = KIND_ERROR;
        endcase
        return k;
    endfunction

endpackage

@@ sv/cts_scan_core.sv @@
// ----------------------------------------------------------------------------
// cts_scan_core
// Scanner state and per-byte decode: up to two tokens for each accepted item.
// ----------------------------------------------------------------------------
module cts_scan_core #(
    parameter int ACC_WIDTH = cts_pkg::ACC_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  logic                op,
    input  logic [7:0]          ch,
    output cts_pkg::scan_out_t  result
);

    cts_pkg::mode_t              mode_reg, mode_next;
    logic [ACC_WIDTH-1:0]        acc_reg, acc_next;
    logic [2:0]                  pos_reg, pos_next;
    logic                        miss_reg, miss_next;

    logic [ACC_WIDTH+3:0]        acc_prod;
    logic                        acc_sat;
    logic [cts_pkg::VALUE_W-1:0] int_val;
    logic                        c_ws, c_digit, c_alpha;
    logic                        has_flush, has_second, run_idle;
    cts_pkg::token_t             pend_tok, second_tok;
    cts_pkg::kind_t              sym;

    // character classes
    assign c_ws    = cts_pkg::is_ws(ch);
    assign c_digit = cts_pkg::is_digit(ch);
    assign c_alpha = cts_pkg::is_alpha(ch);
    assign sym     = cts_pkg::sym_kind(ch);

    // acc * 10 + digit, saturating at the accumulator maximum
    assign acc_prod = ({4'b0000, acc_reg} << 3) + ({4'b0000, acc_reg} << 1)
                    + {{ACC_WIDTH{1'b0}}, ch[3:0]};
    assign acc_sat  = |acc_prod[ACC_WIDTH+3:ACC_WIDTH];

    // reported value clamps at the output field maximum
    generate
        if (ACC_WIDTH > cts_pkg::VALUE_W) begin : g_clamp
            assign int_val = (|acc_reg[ACC_WIDTH-1:cts_pkg::VALUE_W]) ? '1
                           : acc_reg[cts_pkg::VALUE_W-1:0];
        end else if (ACC_WIDTH == cts_pkg::VALUE_W) begin : g_same
            assign int_val = acc_reg;
        end else begin : g_extend
            assign int_val = {{(cts_pkg::VALUE_W-ACC_WIDTH){1'b0}}, acc_reg};
        end
    endgenerate

    // token for the number or word in progress
    always_comb
    begin
        if (mode_reg == cts_pkg::MODE_NUM)
        begin
            pend_tok = cts_pkg::make_tok(cts_pkg::KIND_INT, int_val, cts_pkg::CAUSE_NONE);
        end
        else if (!miss_reg && (pos_reg == cts_pkg::KW_LEN))
        begin
            pend_tok = cts_pkg::make_tok(cts_pkg::KIND_PRINT, '0, cts_pkg::CAUSE_NONE);
        end
        else
        begin
            pend_tok = cts_pkg::make_tok(cts_pkg::KIND_ERROR, '0, cts_pkg::CAUSE_WORD);
        end
    end

    // next state and result tokens
    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        miss_next  = miss_reg;
        has_flush  = 1'b0;
        has_second = 1'b0;
        run_idle   = 1'b0;
        second_tok = cts_pkg::make_tok(cts_pkg::KIND_EOF, '0, cts_pkg::CAUSE_NONE);

        unique case (mode_reg)
            cts_pkg::MODE_NUM:
            begin
                if (op == cts_pkg::OP_EOF)
                begin
                    has_flush = 1'b1;
                end
                else if (c_digit)
                begin
                    acc_next = acc_sat ? '1 : acc_prod[ACC_WIDTH-1:0];
                end
                else
                begin
                    has_flush = 1'b1;
                    run_idle  = 1'b1;
                end
            end
            cts_pkg::MODE_WORD:
            begin
                if ((op == cts_pkg::OP_EOF) || c_ws)
                begin
                    has_flush = 1'b1;
                end
                else if (!miss_reg && (pos_reg < cts_pkg::KW_LEN)
                         && (ch == cts_pkg::kw_char(pos_reg)))
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else
                begin
                    miss_next = 1'b1;
                end
            end
            default:
            begin
                run_idle = (op == cts_pkg::OP_CHAR);
            end
        endcase

        // a flushed token or end of input returns to idle
        if (has_flush || (op == cts_pkg::OP_EOF))
        begin
            mode_next = cts_pkg::MODE_IDLE;
            acc_next  = '0;
            pos_next  = '0;
            miss_next = 1'b0;
        end

        if (op == cts_pkg::OP_EOF)
        begin
            has_second = 1'b1;
        end

        // byte seen while idle
        if (run_idle && !c_ws)
        begin
            if (c_digit)
            begin
                mode_next = cts_pkg::MODE_NUM;
                acc_next  = {{(ACC_WIDTH-4){1'b0}}, ch[3:0]};
            end
            else if (c_alpha)
            begin
                mode_next = cts_pkg::MODE_WORD;
                if (ch == cts_pkg::kw_char(3'd0))
                begin
                    pos_next  = 3'd1;
                    miss_next = 1'b0;
                end
                else
                begin
                    pos_next  = 3'd0;
                    miss_next = 1'b1;
                end
            end
            else
            begin
                has_second = 1'b1;
                second_tok = cts_pkg::make_tok(sym, '0,
                    (sym == cts_pkg::KIND_ERROR) ? cts_pkg::CAUSE_CHAR : cts_pkg::CAUSE_NONE);
            end
        end
    end

    // pack the results in order, last flag on the final one
    always_comb
    begin
        result = '0;
        if (fire)
        begin
            result.count = {1'b0, has_flush} + {1'b0, has_second};
            if (has_flush)
            begin
                result.first       = pend_tok;
                result.first.last  = !has_second;
                result.second      = second_tok;
                result.second.last = 1'b1;
            end
            else
            begin
                result.first       = second_tok;
                result.first.last  = 1'b1;
            end
        end
    end

    // scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= cts_pkg::MODE_IDLE;
            acc_reg  <= '0;
            pos_reg  <= '0;
            miss_reg <= 1'b0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            pos_reg  <= pos_next;
            miss_reg <= miss_next;
        end
    end

endmodule

@@ sv/cts_result_fifo.sv @@
// ----------------------------------------------------------------------------
// cts_result_fifo
// Result queue: up to two tokens in a cycle, one out a cycle on out_ready.
// ----------------------------------------------------------------------------
module cts_result_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  cts_pkg::scan_out_t  push,
    output logic                has_room,
    output logic                out_valid,
    input  logic                out_ready,
    output cts_pkg::token_t     out_tok
);

    localparam int AW = cts_pkg::FIFO_AW;

    cts_pkg::token_t mem_reg [cts_pkg::FIFO_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;
    logic            pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_tok   = mem_reg[rd_ptr_reg];
    // room for two more tokens, independent of the output side
    assign has_room  = (count_reg <= (AW+1)'(cts_pkg::FIFO_DEPTH - 2));

    // pointer and fill updates
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + AW'(push.count);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        count_next  = count_reg + (AW+1)'(push.count) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // token storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + AW'(1)] <= push.second;
        end
    end

endmodule

@@ sv/calculator_token_scanner.sv @@
// ----------------------------------------------------------------------------
// calculator_token_scanner
// Scans calculator source bytes into tokens: integers, print, symbols, errors.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata              | tuser          | tlast
//  s_*      | in  | ch[7:0]            | op[0]          | -
//  m_*      | out | int_value, cause   | token_kind     | last result of item
//
// One input item is taken per cycle while the result queue has room for two
// tokens; each item yields zero, one or two tokens, written into the queue.
// A number ended by a symbol, or end of input after a pending token, gives two
// tokens, which drain one per cycle from a four-entry queue while m_tready is high.
// Reset (rst_n low, asynchronous) returns the scanner to idle and empties the
// queue. A stall on m_tready drops s_tready once more than two tokens are queued.
// ----------------------------------------------------------------------------
module calculator_token_scanner #(
    parameter int ACC_WIDTH = cts_pkg::ACC_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [30:0] int_value, [32:31] error_cause, rest zero
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast
);

    logic               s_fire;
    cts_pkg::scan_out_t scan;
    cts_pkg::token_t    tok;

    assign s_fire = s_tvalid && s_tready;

    // scanner
    cts_scan_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (s_fire),
        .op     (s_tuser[0]),
        .ch     (s_tdata),
        .result (scan)
    );

    // result queue
    cts_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (scan),
        .has_room  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (tok)
    );

    // output packing
    assign m_tdata = {7'b0000000, tok.cause, tok.value};
    assign m_tuser = tok.kind;
    assign m_tlast = tok.last;

`ifndef NO_ASSERTIONS
    // end of input always yields at least the eof token
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_tuser[0] == cts_pkg::OP_EOF)) |-> (scan.count != 2'd0))
        else $error("end of input produced no token");

    // with two tokens only the second carries the last flag
    assert property (@(posedge clk) disable iff (!rst_n)
        (scan.count == 2'd2) |-> (!scan.first.last && scan.second.last))
        else $error("last flag misplaced on a token pair");

    // tokens only come from accepted items
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_fire |-> (scan.count == 2'd0))
        else $error("token produced without an accepted item");
`endif

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for calculator_token_scanner: source bytes and end of
// input items go in on the s_* stream, tokens are predicted per accepted item
// and compared in order against every item taken from the m_* stream, under
// several sender and receiver idling mixes and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ACC_W      = cts_pkg::ACC_WIDTH_DEF;
    localparam logic [63:0] ACC_TOP    = (64'd1 << ACC_W) - 64'd1;
    localparam logic [63:0] VALUE_TOP  = 64'h7FFF_FFFF;
    localparam logic [39:0] KEYWORD    = "print";
    localparam int          TAIL_WAIT  = 16;
    localparam int          STALL_LEN  = 300;
    localparam int          PHASE_ITEMS = 150;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic [0:0]  s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    // predictor state
    cts_pkg::mode_t scan_state;
    logic [63:0]    num_acc;
    logic [2:0]     kw_pos;
    logic           kw_miss;

    cts_pkg::token_t token_q[$];
    cts_pkg::token_t step_toks[$];

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_count     = 0;
    bit          hold_start     = 1'b0;
    int          items_sent     = 0;
    int          fault_count    = 0;

    calculator_token_scanner u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // character classes
    // ------------------------------------------------------------------
    function automatic bit ws_byte(logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit digit_byte(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_byte(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // ------------------------------------------------------------------
    // token predictor
    // ------------------------------------------------------------------
    function automatic void add_token(cts_pkg::kind_t k, logic [63:0] v,
                                      cts_pkg::cause_t c);
        cts_pkg::token_t t;
        t.kind  = k;
        t.value = (v > VALUE_TOP) ? VALUE_TOP[30:0] : v[30:0];
        t.cause = c;
        t.last  = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic void clear_scan();
        scan_state = cts_pkg::MODE_IDLE;
        num_acc    = '0;
        kw_pos     = '0;
        kw_miss    = 1'b0;
    endfunction

    function automatic void keyword_step(logic [7:0] c);
        if (!kw_miss && kw_pos < 3'd5 && c == KEYWORD[8*(4-int'(kw_pos)) +: 8])
            kw_pos = kw_pos + 3'd1;
        else
            kw_miss = 1'b1;
    endfunction

    // emit any pending number or word
    function automatic void flush_scan();
        if (scan_state == cts_pkg::MODE_NUM)
            add_token(cts_pkg::KIND_INT, num_acc, cts_pkg::CAUSE_NONE);
        else if (scan_state == cts_pkg::MODE_WORD)
        begin
            if (!kw_miss && kw_pos == 3'd5)
                add_token(cts_pkg::KIND_PRINT, '0, cts_pkg::CAUSE_NONE);
            else
                add_token(cts_pkg::KIND_ERROR, '0, cts_pkg::CAUSE_WORD);
        end
        clear_scan();
    endfunction

    // byte seen between tokens
    function automatic void idle_scan(logic [7:0] c);
        if (ws_byte(c))
            return;
        if (digit_byte(c))
        begin
            scan_state = cts_pkg::MODE_NUM;
            num_acc    = 64'(c - "0");
            return;
        end
        if (letter_byte(c))
        begin
            scan_state = cts_pkg::MODE_WORD;
            kw_pos     = '0;
            kw_miss    = 1'b0;
            keyword_step(c);
            return;
        end
        case (c)
            cts_pkg::CH_OPEN:  add_token(cts_pkg::KIND_OPEN,  '0, cts_pkg::CAUSE_NONE);
            cts_pkg::CH_CLOSE: add_token(cts_pkg::KIND_CLOSE, '0, cts_pkg::CAUSE_NONE);
            cts_pkg::CH_PLUS:  add_token(cts_pkg::KIND_PLUS,  '0, cts_pkg::CAUSE_NONE);
            cts_pkg::CH_MINUS: add_token(cts_pkg::KIND_MINUS, '0, cts_pkg::CAUSE_NONE);
            cts_pkg::CH_STAR:  add_token(cts_pkg::KIND_MULT,  '0, cts_pkg::CAUSE_NONE);
            cts_pkg::CH_SLASH: add_token(cts_pkg::KIND_DIV,   '0, cts_pkg::CAUSE_NONE);
            default:           add_token(cts_pkg::KIND_ERROR, '0, cts_pkg::CAUSE_CHAR);
        endcase
    endfunction

    // tokens caused by one accepted item, appended to the expected queue
    function automatic void predict_tokens(logic op, logic [7:0] c);
        logic [63:0]     d;
        cts_pkg::token_t t;
        if (op == cts_pkg::OP_EOF)
        begin
            flush_scan();
            add_token(cts_pkg::KIND_EOF, '0, cts_pkg::CAUSE_NONE);
        end
        else if (scan_state == cts_pkg::MODE_NUM)
        begin
            if (digit_byte(c))
            begin
                d = 64'(c - "0");
                if (num_acc > (ACC_TOP - d) / 64'd10)
                    num_acc = ACC_TOP;
                else
                    num_acc = num_acc * 64'd10 + d;
            end
            else
            begin
                flush_scan();
                idle_scan(c);
            end
        end
        else if (scan_state == cts_pkg::MODE_WORD)
        begin
            if (ws_byte(c))
                flush_scan();
            else
                keyword_step(c);
        end
        else
            idle_scan(c);

        for (int i = 0; i < step_toks.size(); i++)
        begin
            t      = step_toks[i];
            t.last = (i == step_toks.size() - 1);
            token_q.push_back(t);
        end
        step_toks.delete();
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [7:0] c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_tokens(op, c);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(cts_pkg::OP_CHAR, s[i]);
    endtask

    // sender stops until every expected token has come out
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (token_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_ws();
        logic [7:0] w;
        w = 8'($urandom_range(8, 13));
        return (w == 8'd8) ? 8'd32 : w;
    endfunction

    function automatic logic [7:0] pick_sym();
        case ($urandom_range(0, 5))
            0:       return cts_pkg::CH_OPEN;
            1:       return cts_pkg::CH_CLOSE;
            2:       return cts_pkg::CH_PLUS;
            3:       return cts_pkg::CH_MINUS;
            4:       return cts_pkg::CH_STAR;
            default: return cts_pkg::CH_SLASH;
        endcase
    endfunction

    function automatic logic [7:0] pick_non_ws();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (ws_byte(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] b;
        b = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) == 1) ? 8'("a" + b) : 8'("A" + b);
    endfunction

    // what ends a number or a word
    task automatic send_terminator();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            send_item(cts_pkg::OP_CHAR, pick_ws());
        else if (r < 85)
            send_item(cts_pkg::OP_CHAR, pick_sym());
        else if (r < 95)
            send_item(cts_pkg::OP_EOF, 8'($urandom_range(0, 255)));
    endtask

    // one random token with random content
    task automatic send_random_token();
        int    r;
        int    len;
        string kw;
        kw = "print";
        r  = $urandom_range(0, 99);
        if (r < 25)
        begin
            // mostly short numbers, a few long enough to saturate
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
            repeat (len)
                send_item(cts_pkg::OP_CHAR, 8'("0" + $urandom_range(0, 9)));
            send_terminator();
        end
        else if (r < 50)
        begin
            case ($urandom_range(0, 4))
                0, 1: send_text(kw);
                // a strict prefix of the keyword
                2:    send_text(kw.substr(0, int'($urandom_range(0, 3))));
                3:
                begin
                    send_text(kw);
                    repeat ($urandom_range(1, 2))
                        send_item(cts_pkg::OP_CHAR, pick_non_ws());
                end
                default:
                begin
                    send_item(cts_pkg::OP_CHAR, pick_letter());
                    repeat ($urandom_range(0, 5))
                        send_item(cts_pkg::OP_CHAR, pick_non_ws());
                end
            endcase
            send_terminator();
        end
        else if (r < 70)
            send_item(cts_pkg::OP_CHAR, pick_sym());
        else if (r < 85)
            send_item(cts_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        else if (r < 92)
            send_item(cts_pkg::OP_EOF, 8'($urandom_range(0, 255)));
        else
            send_item(cts_pkg::OP_CHAR, pick_ws());
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_symbols();
        send_text("()+-*/");
    endtask

    // number closed by a symbol gives two tokens, zero value too
    task automatic test_number_end();
        send_text("7/0 ");
    endtask

    task automatic test_keyword();
        send_text("print");
        send_item(cts_pkg::OP_CHAR, 8'd9);
    endtask

    task automatic test_bad_word();
        send_text("pr");
        send_item(cts_pkg::OP_EOF, 8'h00);
    endtask

    task automatic test_invalid_bytes();
        send_item(cts_pkg::OP_CHAR, 8'hFF);
        send_item(cts_pkg::OP_CHAR, 8'h80);
        send_item(cts_pkg::OP_CHAR, 8'h00);
    endtask

    // flush of a pending number, then eof with nothing pending
    task automatic test_end_of_input();
        send_item(cts_pkg::OP_CHAR, "5");
        send_item(cts_pkg::OP_EOF, 8'hFF);
        send_item(cts_pkg::OP_EOF, 8'h00);
    endtask

    // long output stall while the sender keeps offering items
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b1;
        repeat (24)
            send_item(cts_pkg::OP_CHAR, pick_sym());
        wait_drain();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at        = items_sent + PHASE_ITEMS;
        while (items_sent < stop_at)
            send_random_token();
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus one counted hold-off
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_start = 1'b0;
            hold_count = STALL_LEN;
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_count > 0)
        begin
            m_tready   <= 1'b0;
            hold_count = hold_count - 1;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // token checker
    // ------------------------------------------------------------------
    task automatic report_fault(input string what, input cts_pkg::token_t want,
                                input cts_pkg::token_t got);
        fault_count++;
        if (fault_count <= 10)
            $display({"%0t %s: expected kind %0d value %0d cause %0d last %0b,",
                      " got kind %0d value %0d cause %0d last %0b"},
                     $time, what, want.kind, want.value, want.cause, want.last,
                     got.kind, got.value, got.cause, got.last);
    endtask

    always @(posedge clk)
    begin : token_check
        cts_pkg::token_t got;
        cts_pkg::token_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind  = cts_pkg::kind_t'(m_tuser);
            got.value = m_tdata[30:0];
            got.cause = cts_pkg::cause_t'(m_tdata[32:31]);
            got.last  = m_tlast;
            if (token_q.size() == 0)
                report_fault("unexpected token", '0, got);
            else
            begin
                want = token_q.pop_front();
                if (got.kind !== want.kind || got.value !== want.value ||
                    got.cause !== want.cause || got.last !== want.last)
                    report_fault("token mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial
    begin
        clear_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_symbols();
        test_number_end();
        test_keyword();
        test_bad_word();
        test_invalid_bytes();
        test_end_of_input();
        wait_drain();

        test_backpressure();

        test_random(0, 0);
        test_random(84, 0);
        test_random(0, 84);
        test_random(33, 33);

        wait_drain();
        repeat (TAIL_WAIT) @(posedge clk);
        if (fault_count == 0 && token_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
